### src/tpql_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree path query package
// Field widths, operation codes and item types shared by the tree path
// query engine, its channels and its helper units.
// ----------------------------------------------------------------------------
package tpql_pkg;

	localparam int OP_W       = 2;
	localparam int NODE_FW    = 10;
	localparam int WEIGHT_FW  = 20;
	localparam int POS_W      = 11;
	localparam int ANSWER_W   = 32;
	localparam int DEPTH_W    = 10;
	localparam int SUM_W      = 30;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [ANSWER_W-1:0] ANSWER_MAX = '1;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_COST = 2'd1;
	localparam logic [OP_W-1:0] OP_KTH  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [NODE_FW-1:0]   node_a;
		logic [NODE_FW-1:0]   node_b;
		logic [WEIGHT_FW-1:0] edge_weight;
		logic [POS_W-1:0]     position;
	} req_item_t;

	typedef struct packed {
		logic [ANSWER_W-1:0] answer;
		logic                error;
	} rsp_item_t;

endpackage

### src/tpql_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree path query stream channel
// Valid and ready handshake with a typed payload; one transfer per edge at
// which valid and ready are both high.
// ----------------------------------------------------------------------------
interface tpql_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/tpql_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree path query RAM
// Generic synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tpql_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr0,
	output logic [WIDTH-1:0]           rdata0,
	input  logic [$clog2(DEPTH)-1:0]   raddr1,
	output logic [WIDTH-1:0]           rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

### src/tpql_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree path query node fold
// Reduces two node fields modulo the node count by reciprocal
// multiplication: a registered quotient first, then the remainder.
// ----------------------------------------------------------------------------
module tpql_fold #(
	parameter int NODES = 1024,
	parameter int NW    = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tpql_pkg::NODE_FW-1:0]   a_in,
	input  logic [tpql_pkg::NODE_FW-1:0]   b_in,
	output logic                           done,
	output logic [NW-1:0]                  a_out,
	output logic [NW-1:0]                  b_out
);
	import tpql_pkg::*;

	localparam int RECIP_SH = 21;
	localparam int RECIP    = ((2 ** RECIP_SH) + NODES - 1) / NODES;

	logic [NODE_FW-1:0] va_q, vb_q, qa_q, qb_q;
	logic               busy_q, phase_q;
	logic [31:0]        prod_a, prod_b, rem_a, rem_b;

	assign prod_a = 32'(va_q) * 32'(RECIP);
	assign prod_b = 32'(vb_q) * 32'(RECIP);
	assign rem_a  = 32'(va_q) - 32'(qa_q) * 32'(NODES);
	assign rem_b  = 32'(vb_q) - 32'(qb_q) * 32'(NODES);
	assign a_out  = rem_a[NW-1:0];
	assign b_out  = rem_b[NW-1:0];
	assign done   = busy_q && phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			va_q    <= '0;
			vb_q    <= '0;
			qa_q    <= '0;
			qb_q    <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			va_q    <= a_in;
			vb_q    <= b_in;
		end else if (busy_q) begin
			if (!phase_q) begin
				qa_q    <= prod_a[RECIP_SH +: NODE_FW];
				qb_q    <= prod_b[RECIP_SH +: NODE_FW];
				phase_q <= 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

### src/tree_path_query_lifting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree path query engine with binary lifting
// Loads a weighted rooted tree node by node and answers path cost and
// k-th node on path queries from ancestor and summed-weight tables.
// ----------------------------------------------------------------------------
// Usage: items arrive on req and results leave on rsp, both valid/ready
// channels. A transfer on req with op load stores the node's depth and its
// row of 2^i-th ancestors and summed weights and gives no result. A cost or
// k-th query gives exactly one result on rsp; op code 3 is dropped.
// The engine works on one item at a time: req is ready only while idle.
// Each load or query first folds its node indexes into range. A load
// then writes its lifting row one level at a time on the single write
// port, each level above the first of a non-root node after a read. A
// query does a lift to equal depth, a descent over all levels unless the
// nodes already meet, then a cost walk or a second lift unless the k-th
// answer is settled, each taken step a read of the lifting RAM followed
// by its update. req is ready again in the cycle after an item finishes.
// Results go to an output register; while rsp stalls with a result still
// held there, a finished result waits in the engine and req stays low.
// The tables are not cleared at reset; asynchronous reset returns the
// control to idle and empties the output register.
// ----------------------------------------------------------------------------
module tree_path_query_lifting #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input logic           clk,
	input logic           arst_n,
	tpql_stream_if.sink   req,
	tpql_stream_if.source rsp
);
	import tpql_pkg::*;

	localparam int NW         = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW         = $clog2(LEVELS + 1);
	localparam int LIFT_DEPTH = NODES * (2 ** LW);
	localparam int LIFT_W     = NW + SUM_W;
	localparam int LA_W       = NW + LW;

	typedef enum logic [4:0] {
		S_IDLE, S_FOLD, S_LD_ROOT, S_LD_RD, S_LD_D, S_LD_RD_L, S_LD_WR_L,
		S_Q_RD, S_Q_DEP, S_LIFT_RD, S_LIFT_WT, S_CMP, S_DESC_RD, S_DESC_WT,
		S_TOP_RD, S_TOP_WT, S_TD_RD, S_DIST, S_COST_RD, S_COST_WT, S_KTH,
		S_DONE
	} state_t;

	typedef enum logic {RET_LCA, RET_KTH} ret_t;

	state_t                 state_q;
	ret_t                   ret_q;
	logic [OP_W-1:0]        op_q;
	logic [NW-1:0]          a_q, b_q, u_q, v_q, top_q, cur_q;
	logic [WEIGHT_FW-1:0]   w_q;
	logic [POS_W-1:0]       k_q;
	logic [SUM_W-1:0]       curw_q;
	logic [DEPTH_W-1:0]     da_q, db_q, la_q, lb_q;
	logic [CW-1:0]          lvl_q;
	logic [LEVELS-1:0]      steps_q;
	logic                   take_a_q, take_b_q;
	logic [ANSWER_W-1:0]    acc_q, res_ans_q, answer_q;
	logic                   res_err_q, error_q, rsp_valid_q;

	logic                   accept, fold_start, fold_done;
	logic [NW-1:0]          fold_a, fold_b;

	logic                   dep_we;
	logic [NW-1:0]          dep_wa, dep_ra0, dep_ra1;
	logic [DEPTH_W-1:0]     dep_wd, dep_rd0, dep_rd1, dep_inc;
	logic                   lift_we;
	logic [LA_W-1:0]        lift_wa, lift_ra0, lift_ra1;
	logic [LIFT_W-1:0]      lift_wd, lift_rd0, lift_rd1;
	logic [NW-1:0]          anc0, anc1;
	logic [SUM_W-1:0]       wt0, wt1, wsum_sat;
	logic [SUM_W:0]         wsum;
	logic [CW-1:0]          lvl_m1;
	logic [LW-1:0]          lvl_ix;

	logic [26:0]            diff_ext, km_ext, far_ext;
	logic [DEPTH_W-1:0]     diff_ab;
	logic [POS_W-1:0]       km, la11, lb11, far;
	logic [POS_W:0]         total;
	logic [DEPTH_W-1:0]     dt, la_n, lb_n;
	logic [ANSWER_W+1:0]    cost_sum;
	logic [ANSWER_W-1:0]    acc_n;

	assign accept     = req.valid && req.ready;
	assign fold_start = accept && (req.data.op != OP_NONE);
	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = '{answer: answer_q, error: error_q};

	tpql_fold #(.NODES(NODES), .NW(NW)) u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fold_start),
		.a_in   (req.data.node_a),
		.b_in   (req.data.node_b),
		.done   (fold_done),
		.a_out  (fold_a),
		.b_out  (fold_b)
	);

	tpql_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_depth_ram (
		.clk    (clk),
		.we     (dep_we),
		.waddr  (dep_wa),
		.wdata  (dep_wd),
		.raddr0 (dep_ra0),
		.rdata0 (dep_rd0),
		.raddr1 (dep_ra1),
		.rdata1 (dep_rd1)
	);

	tpql_ram #(.WIDTH(LIFT_W), .DEPTH(LIFT_DEPTH)) u_lift_ram (
		.clk    (clk),
		.we     (lift_we),
		.waddr  (lift_wa),
		.wdata  (lift_wd),
		.raddr0 (lift_ra0),
		.rdata0 (lift_rd0),
		.raddr1 (lift_ra1),
		.rdata1 (lift_rd1)
	);

	assign anc0     = lift_rd0[LIFT_W-1 -: NW];
	assign anc1     = lift_rd1[LIFT_W-1 -: NW];
	assign wt0      = lift_rd0[SUM_W-1:0];
	assign wt1      = lift_rd1[SUM_W-1:0];
	assign wsum     = {1'b0, curw_q} + {1'b0, wt0};
	assign wsum_sat = wsum[SUM_W] ? SUM_MAX : wsum[SUM_W-1:0];
	assign dep_inc  = (dep_rd0 == DEPTH_MAX) ? DEPTH_MAX : dep_rd0 + 1'b1;
	assign lvl_m1   = lvl_q - 1'b1;
	assign lvl_ix   = lvl_q[LW-1:0];

	assign diff_ab  = (dep_rd0 < dep_rd1) ? dep_rd1 - dep_rd0 : dep_rd0 - dep_rd1;
	assign diff_ext = {17'b0, diff_ab};

	assign km       = k_q - 1'b1;
	assign la11     = {1'b0, la_q};
	assign lb11     = {1'b0, lb_q};
	assign total    = {1'b0, la11} + {1'b0, lb11} + 1'b1;
	assign far      = lb11 + la11 - km;
	assign km_ext   = {16'b0, km};
	assign far_ext  = {16'b0, far};

	assign dt       = dep_rd0;
	assign la_n     = (da_q >= dt) ? da_q - dt : '0;
	assign lb_n     = (db_q >= dt) ? db_q - dt : '0;

	assign cost_sum = {2'b0, acc_q} + (take_a_q ? (ANSWER_W + 2)'(wt0) : '0)
		+ (take_b_q ? (ANSWER_W + 2)'(wt1) : '0);
	assign acc_n    = (cost_sum > {2'b0, ANSWER_MAX}) ? ANSWER_MAX : cost_sum[ANSWER_W-1:0];

	always_comb begin
		dep_we   = 1'b0;
		dep_wa   = a_q;
		dep_wd   = '0;
		dep_ra0  = a_q;
		dep_ra1  = b_q;
		lift_we  = 1'b0;
		lift_wa  = {a_q, lvl_ix};
		lift_wd  = '0;
		lift_ra0 = {u_q, lvl_ix};
		lift_ra1 = {v_q, lvl_ix};
		unique case (state_q)
			S_LD_ROOT: begin
				lift_we = 1'b1;
				lift_wd = {a_q, {SUM_W{1'b0}}};
				dep_we  = (lvl_q == '0);
			end
			S_LD_RD: begin
				dep_ra0 = b_q;
			end
			S_LD_D: begin
				dep_we  = 1'b1;
				dep_wd  = dep_inc;
				lift_we = 1'b1;
				lift_wa = {a_q, {LW{1'b0}}};
				lift_wd = {b_q, {(SUM_W - WEIGHT_FW){1'b0}}, w_q};
			end
			S_LD_RD_L: begin
				lift_ra0 = {cur_q, lvl_m1[LW-1:0]};
			end
			S_LD_WR_L: begin
				lift_we = 1'b1;
				lift_wd = {anc0, wsum_sat};
			end
			S_TOP_RD: begin
				lift_ra0 = {u_q, {LW{1'b0}}};
			end
			S_TD_RD: begin
				dep_ra0 = top_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_LCA;
			lvl_q       <= '0;
			rsp_valid_q <= 1'b0;
			op_q        <= OP_NONE;
			a_q         <= '0;
			b_q         <= '0;
			u_q         <= '0;
			v_q         <= '0;
			top_q       <= '0;
			cur_q       <= '0;
			w_q         <= '0;
			k_q         <= '0;
			curw_q      <= '0;
			da_q        <= '0;
			db_q        <= '0;
			la_q        <= '0;
			lb_q        <= '0;
			steps_q     <= '0;
			take_a_q    <= 1'b0;
			take_b_q    <= 1'b0;
			acc_q       <= '0;
			res_ans_q   <= '0;
			res_err_q   <= 1'b0;
			answer_q    <= '0;
			error_q     <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fold_start) begin
						op_q    <= req.data.op;
						w_q     <= req.data.edge_weight;
						k_q     <= req.data.position;
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (fold_done) begin
						a_q   <= fold_a;
						b_q   <= fold_b;
						lvl_q <= '0;
						if (op_q == OP_LOAD) begin
							state_q <= (fold_a == fold_b) ? S_LD_ROOT : S_LD_RD;
						end else begin
							state_q <= S_Q_RD;
						end
					end
				end
				S_LD_ROOT: begin
					if (lvl_q == CW'(LEVELS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_D;
				end
				S_LD_D: begin
					cur_q  <= b_q;
					curw_q <= {{(SUM_W - WEIGHT_FW){1'b0}}, w_q};
					lvl_q  <= CW'(1);
					state_q <= (LEVELS == 1) ? S_IDLE : S_LD_RD_L;
				end
				S_LD_RD_L: begin
					state_q <= S_LD_WR_L;
				end
				S_LD_WR_L: begin
					cur_q  <= anc0;
					curw_q <= wsum_sat;
					if (lvl_q == CW'(LEVELS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= S_LD_RD_L;
					end
				end
				S_Q_RD: begin
					state_q <= S_Q_DEP;
				end
				S_Q_DEP: begin
					da_q    <= dep_rd0;
					db_q    <= dep_rd1;
					u_q     <= (dep_rd0 < dep_rd1) ? b_q : a_q;
					v_q     <= (dep_rd0 < dep_rd1) ? a_q : b_q;
					steps_q <= diff_ext[LEVELS-1:0];
					lvl_q   <= '0;
					ret_q   <= RET_LCA;
					state_q <= S_LIFT_RD;
				end
				S_LIFT_RD: begin
					if (lvl_q == CW'(LEVELS)) begin
						if (ret_q == RET_LCA) begin
							state_q <= S_CMP;
						end else begin
							res_ans_q <= ANSWER_W'(u_q);
							res_err_q <= 1'b0;
							state_q   <= S_DONE;
						end
					end else if (steps_q[lvl_ix]) begin
						state_q <= S_LIFT_WT;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_LIFT_WT: begin
					u_q     <= anc0;
					lvl_q   <= lvl_q + 1'b1;
					state_q <= S_LIFT_RD;
				end
				S_CMP: begin
					if (u_q == v_q) begin
						top_q   <= u_q;
						state_q <= S_TD_RD;
					end else begin
						lvl_q   <= CW'(LEVELS - 1);
						state_q <= S_DESC_RD;
					end
				end
				S_DESC_RD: begin
					state_q <= S_DESC_WT;
				end
				S_DESC_WT: begin
					if (anc0 != anc1) begin
						u_q <= anc0;
						v_q <= anc1;
					end
					if (lvl_q == '0) begin
						state_q <= S_TOP_RD;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						state_q <= S_DESC_RD;
					end
				end
				S_TOP_RD: begin
					state_q <= S_TOP_WT;
				end
				S_TOP_WT: begin
					top_q   <= anc0;
					state_q <= S_TD_RD;
				end
				S_TD_RD: begin
					state_q <= S_DIST;
				end
				S_DIST: begin
					la_q  <= la_n;
					lb_q  <= lb_n;
					u_q   <= a_q;
					v_q   <= b_q;
					acc_q <= '0;
					lvl_q <= CW'(LEVELS - 1);
					state_q <= (op_q == OP_COST) ? S_COST_RD : S_KTH;
				end
				S_COST_RD: begin
					take_a_q <= (la_q >> lvl_q) != '0;
					take_b_q <= (lb_q >> lvl_q) != '0;
					state_q  <= S_COST_WT;
				end
				S_COST_WT: begin
					acc_q <= acc_n;
					if (take_a_q) begin
						u_q  <= anc0;
						la_q <= la_q - (DEPTH_W'(1) << lvl_q);
					end
					if (take_b_q) begin
						v_q  <= anc1;
						lb_q <= lb_q - (DEPTH_W'(1) << lvl_q);
					end
					if (lvl_q == '0) begin
						res_ans_q <= acc_n;
						res_err_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						state_q <= S_COST_RD;
					end
				end
				S_KTH: begin
					lvl_q <= '0;
					ret_q <= RET_KTH;
					if (k_q == '0 || {1'b0, k_q} > total) begin
						res_ans_q <= '0;
						res_err_q <= 1'b1;
						state_q   <= S_DONE;
					end else if (km == la11) begin
						res_ans_q <= ANSWER_W'(top_q);
						res_err_q <= 1'b0;
						state_q   <= S_DONE;
					end else if (km < la11) begin
						u_q     <= a_q;
						steps_q <= km_ext[LEVELS-1:0];
						state_q <= S_LIFT_RD;
					end else begin
						u_q     <= b_q;
						steps_q <= far_ext[LEVELS-1:0];
						state_q <= S_LIFT_RD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						answer_q    <= res_ans_q;
						error_q     <= res_err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing state");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.data.op == OP_LOAD) |=> !$rose(rsp_valid_q))
		else $error("load produced a result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && error_q) |-> (answer_q == '0))
		else $error("error result carries a nonzero answer");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= CW'(LEVELS))
		else $error("level counter out of range");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready)
		else $error("input ready while an item is in progress");
`endif
endmodule

### tb/sv/tree_path_query_lifting_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree path query engine testbench
// Builds random weighted trees by ordered node loads interleaved with path
// cost and k-th node queries, checking each result against an in-bench lifting
// predictor, under several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tree_path_query_lifting_tb;
	import tpql_pkg::*;

	class path_answer_board;
		localparam int N = 1024;
		localparam int L = 10;
		logic [DEPTH_W-1:0] depth_of [N];
		logic [NODE_FW-1:0] up_of [N][L];
		logic [SUM_W-1:0] sum_of [N][L];
		rsp_item_t pending_answers[$];
		int errors;
		int checked;

		function new();
			errors = 0;
			checked = 0;
			foreach (depth_of[i]) depth_of[i] = '0;
			foreach (up_of[i, j]) begin
				up_of[i][j] = '0;
				sum_of[i][j] = '0;
			end
		endfunction

		function logic [NODE_FW-1:0] climb(logic [NODE_FW-1:0] n, int steps);
			for (int i = 0; i < L; i++)
				if ((steps >> i) & 1) n = up_of[n][i];
			return n;
		endfunction

		function logic [NODE_FW-1:0] meet(logic [NODE_FW-1:0] a, logic [NODE_FW-1:0] b);
			logic [NODE_FW-1:0] t;
			if (depth_of[a] < depth_of[b]) begin
				t = a; a = b; b = t;
			end
			a = climb(a, int'(depth_of[a]) - int'(depth_of[b]));
			if (a == b) return a;
			for (int i = L - 1; i >= 0; i--)
				if (up_of[a][i] != up_of[b][i]) begin
					a = up_of[a][i];
					b = up_of[b][i];
				end
			return up_of[a][0];
		endfunction

		function int span(logic [NODE_FW-1:0] n, logic [NODE_FW-1:0] top);
			return depth_of[n] >= depth_of[top] ? int'(depth_of[n]) - int'(depth_of[top]) : 0;
		endfunction

		function void note_request(req_item_t r);
			logic [NODE_FW-1:0] a, b, top, m;
			int la, lb, k;
			longint unsigned acc;
			rsp_item_t res;
			a = r.node_a;
			b = r.node_b;
			res = '0;
			if (r.op == OP_LOAD) begin
				if (a == b) begin
					depth_of[a] = '0;
					for (int i = 0; i < L; i++) begin
						up_of[a][i] = a;
						sum_of[a][i] = '0;
					end
				end else begin
					depth_of[a] = (depth_of[b] == DEPTH_MAX) ? DEPTH_MAX : depth_of[b] + 1'b1;
					up_of[a][0] = b;
					sum_of[a][0] = SUM_W'(r.edge_weight);
					for (int i = 1; i < L; i++) begin
						m = up_of[a][i-1];
						up_of[a][i] = up_of[m][i-1];
						acc = longint'(sum_of[a][i-1]) + longint'(sum_of[m][i-1]);
						sum_of[a][i] = acc > SUM_MAX ? SUM_MAX : SUM_W'(acc);
					end
				end
				return;
			end
			if (r.op == OP_NONE) return;
			top = meet(a, b);
			la = span(a, top);
			lb = span(b, top);
			if (r.op == OP_COST) begin
				acc = 0;
				for (int i = L - 1; i >= 0; i--) begin
					if ((1 << i) <= la) begin
						acc += sum_of[a][i];
						a = up_of[a][i];
						la -= 1 << i;
					end
					if ((1 << i) <= lb) begin
						acc += sum_of[b][i];
						b = up_of[b][i];
						lb -= 1 << i;
					end
				end
				res.answer = acc > ANSWER_MAX ? ANSWER_MAX : ANSWER_W'(acc);
			end else begin
				k = int'(r.position);
				if (k == 0 || k > la + lb + 1) res.error = 1'b1;
				else begin
					k -= 1;
					if (k == la) res.answer = ANSWER_W'(top);
					else if (k < la) res.answer = ANSWER_W'(climb(a, k));
					else res.answer = ANSWER_W'(climb(b, lb - (k - la)));
				end
			end
			pending_answers = {pending_answers, res};
		endfunction

		task report(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task check_result(rsp_item_t got);
			rsp_item_t want;
			if (pending_answers.size() == 0) begin
				report($sformatf("unexpected result answer=%0d", got.answer));
				return;
			end
			want = pending_answers.pop_front();
			checked++;
			if (got.answer !== want.answer)
				report($sformatf("answer %0d, wanted %0d", got.answer, want.answer));
			if (got.error !== want.error)
				report($sformatf("error %0b, wanted %0b", got.error, want.error));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit stall_go = 1'b0;
	bit holding = 1'b0;
	int loaded[$];
	int sent = 0;
	path_answer_board board;

	tpql_stream_if #(.T(req_item_t)) req ();
	tpql_stream_if #(.T(rsp_item_t)) rsp ();

	tree_path_query_lifting dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("timeout");
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) board.check_result(rsp.data);
		if (holding)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		wait (stall_go);
		@(posedge clk);
		holding <= 1'b1;
		repeat (400) @(posedge clk);
		holding <= 1'b0;
	end

	task automatic send(req_item_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		board.note_request(r);
		sent++;
		if (r.op == OP_LOAD) loaded = {loaded, int'(r.node_a)};
	endtask

	task automatic put(logic [OP_W-1:0] op, int a, int b, int w, int k);
		req_item_t r;
		r.op = op;
		r.node_a = NODE_FW'(a);
		r.node_b = NODE_FW'(b);
		r.edge_weight = WEIGHT_FW'(w);
		r.position = POS_W'(k);
		send(r);
	endtask

	function automatic int pick_node();
		return loaded[$urandom_range(loaded.size() - 1)];
	endfunction

	task automatic random_query();
		int a, b;
		a = pick_node();
		b = pick_node();
		case ($urandom_range(3))
			0: put(OP_COST, a, b, $urandom, 0);
			1: put(OP_KTH, a, b, $urandom, $urandom_range(2047));
			2: put(OP_KTH, a, b, $urandom, $urandom_range(0, 12));
			default: put(OP_NONE, a, b, $urandom, $urandom);
		endcase
	endtask

	task automatic random_phase(int idle, int stall, int count);
		int fresh;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30) begin
				fresh = $urandom_range(1023);
				put(OP_LOAD, fresh, pick_node(), $urandom_range(0, 20'hFFFFF), $urandom);
			end else
				random_query();
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: a chain with heavy weights, a side branch, and self roots.
		put(OP_LOAD, 0, 0, 20'hFFFFF, 0);
		put(OP_LOAD, 1023, 0, 20'hFFFFF, 0);
		for (int i = 1; i < 12; i++) put(OP_LOAD, i, (i == 1) ? 1023 : i - 1, 20'hFFFFF, 0);
		put(OP_LOAD, 500, 0, 0, 0);
		put(OP_LOAD, 501, 500, 7, 0);
		put(OP_COST, 11, 501, 0, 0);
		put(OP_COST, 1023, 1023, 0, 0);
		put(OP_KTH, 11, 501, 0, 0);
		put(OP_KTH, 11, 501, 0, 1);
		put(OP_KTH, 11, 501, 0, 13);
		put(OP_KTH, 11, 501, 0, 15);
		put(OP_KTH, 11, 501, 0, 16);
		put(OP_KTH, 501, 11, 0, 2047);
		put(OP_NONE, 3, 5, 1, 1);
		put(OP_LOAD, 5, 5, 9, 0);
		put(OP_COST, 5, 5, 0, 0);
		// Long stall of the receiver while the sender keeps offering.
		stall_go = 1'b1;
		for (int i = 0; i < 10; i++) random_query();
		random_phase(0, 0, 150);
		random_phase(65, 0, 150);
		random_phase(0, 65, 150);
		random_phase(17, 17, 150);
		req.valid <= 1'b0;
		while (board.pending_answers.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d items over a tree of %0d loads; checked %0d results.",
			sent, loaded.size(), board.checked);
		if (board.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
